@@ hw/rtl/ensp_pkg.sv @@
// Shared types and constants for the edge near-clip and screen projection block.
// No dependencies; imported by ensp_div and the top level.
`default_nettype none

package ensp_pkg;

	localparam int COORD_FRAC_BITS_DEF = 16;
	localparam int T_BITS = 30;
	localparam int IN_W = 32;
	localparam int OUT_W = 24;
	localparam int SIZE_W = 13;
	localparam int SNAP_W = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int DIV_NUM_W = 64;
	localparam int DIV_DEN_W = 33;
	localparam int DIV_CNT_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SNAP_STEP = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SEGMENTS = 2'd3;

	localparam logic [SIZE_W-1:0] WIDTH_RST = 13'd1920;
	localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd1080;
	localparam logic [SIZE_W-1:0] MAXSEG_RST = 13'd1024;

	localparam logic [DIV_CNT_W-1:0] CLIP_ITERS = 7'd62;
	localparam logic [DIV_CNT_W-1:0] PROJ_ITERS = 7'd54;
	localparam logic [DIV_CNT_W-1:0] SNAP_ITERS = 7'd25;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_CLIP_DIV,
		ST_CLIP_WAIT,
		ST_CUT_MUL,
		ST_CUT_ADD,
		ST_PROJ_MUL,
		ST_PROJ_DIV,
		ST_PROJ_WAIT,
		ST_SNAP_DIV,
		ST_SNAP_WAIT,
		ST_SNAP_MUL,
		ST_SNAP_SAT,
		ST_NEXT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_CNT_W-1:0] iters;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

endpackage

`default_nettype wire

@@ hw/rtl/ensp_div.sv @@
// Shared restoring divider, one quotient bit per cycle, numerator left-aligned.
// Depends on ensp_pkg.
`default_nettype none

module ensp_div (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire ensp_pkg::div_req_t                req,
	output logic                                   done,
	output logic [ensp_pkg::DIV_NUM_W-1:0]         quot
);
	import ensp_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_NUM_W-1:0] quot_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W:0]   rem_q;
	logic [DIV_DEN_W:0]   rem_sh;
	logic                 ge;

	assign rem_sh = {rem_q[DIV_DEN_W-1:0], num_q[DIV_NUM_W-1]};
	assign ge = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= req.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_NUM_W-2:0], 1'b0};
			rem_q <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
			quot_q <= {quot_q[DIV_NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

@@ hw/rtl/edge_near_clip_and_screen_project.sv @@
// Top level: near-plane edge clip, perspective divide, viewport map, clamp, snap.
// Depends on ensp_pkg and ensp_div.
//
// channel | dir | handshake                | payload
// s       | in  | s_tvalid / s_tready      | s_tdata edge, s_tuser frame_start
// m       | out | m_tvalid / m_tready      | m_tdata screen segment
// cfg     | in  | cfg_we                   | cfg_index, cfg_data
//
// Edges are processed on the single bit-serial divider: a clipped edge takes one clip
// division, then each of the four coordinates takes a projection division and, with
// snapping on, a snap division; a dropped edge returns to idle from the check step.
// s_tready is high only in the idle state; a finished segment sits in the output
// register while the next edge is taken, and the emit step stalls while it is still
// held. Reset clears the counter and output valid and loads the register defaults.
`default_nettype none

module edge_near_clip_and_screen_project #(
	parameter int COORD_FRAC_BITS = ensp_pkg::COORD_FRAC_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// a_x, a_y, a_w, b_x, b_y, b_w, caster_tag
	input  wire logic [7*ensp_pkg::IN_W-1:0]        s_tdata,
	// frame_start
	input  wire logic                               s_tuser,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// screen_ax, screen_ay, screen_bx, screen_by, segment_tag
	output logic [4*ensp_pkg::OUT_W+ensp_pkg::IN_W-1:0] m_tdata,
	input  wire logic                               cfg_we,
	input  wire logic [ensp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ensp_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import ensp_pkg::*;

	localparam int NEAR_W_INT = ((1 << COORD_FRAC_BITS) + 50) / 100;
	localparam logic signed [IN_W-1:0] NEAR_W = IN_W'(NEAR_W_INT);
	localparam logic [65:0] CUT_HALF = 66'(1) << (T_BITS - 1);

	state_t state_q, state_d;

	logic [SIZE_W-1:0] width_q, height_q, maxseg_q, cnt_q;
	logic [SNAP_W-1:0] snap_q;

	logic signed [IN_W-1:0] c_q [4];
	logic signed [IN_W-1:0] w_q [2];
	logic signed [OUT_W-1:0] s_q [4];
	logic [IN_W-1:0] tag_q;
	logic fs_q, bsel_q, half_q, neg_q;
	logic [1:0] k_q;
	logic [T_BITS:0] t_q;
	logic m_valid_q;
	logic [4*OUT_W+IN_W-1:0] m_data_q;

	logic signed [33:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [65:0] prod_q;

	div_req_t div_req;
	logic div_done;
	logic [DIV_NUM_W-1:0] div_quot;

	ensp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	logic [SIZE_W-1:0] cnt_eff;
	logic behind_a, behind_b, cnt_full;
	logic signed [IN_W-1:0] pc, qc, pw, qw, cur_c, cur_w;
	logic [SIZE_W-1:0] cur_size, max_size;
	logic [22:0] limit;
	logic signed [32:0] near_diff, clip_den, cur_sum;
	logic [65:0] prod_mag, cut_rnd;
	logic [33:0] cut_r;
	logic signed [33:0] cut_sum;
	logic [53:0] proj_num, proj_q;
	logic [22:0] proj_clamp;
	logic signed [OUT_W-1:0] cur_s;
	logic [OUT_W-1:0] snap_mag;
	logic [24:0] snap_num;
	logic snap_over_p, snap_over_n;
	logic signed [OUT_W-1:0] snap_res;
	logic zero_len, out_free;

	assign cnt_eff = fs_q ? '0 : cnt_q;
	assign cnt_full = cnt_eff >= maxseg_q;
	assign behind_a = w_q[0] < NEAR_W;
	assign behind_b = w_q[1] < NEAR_W;

	assign pc = c_q[{bsel_q, half_q}];
	assign qc = c_q[{~bsel_q, half_q}];
	assign pw = w_q[bsel_q];
	assign qw = w_q[~bsel_q];
	assign near_diff = 33'(NEAR_W) - 33'(pw);
	assign clip_den = 33'(qw) - 33'(pw);

	assign cur_c = c_q[k_q];
	assign cur_w = w_q[k_q[1]];
	assign cur_size = k_q[0] ? height_q : width_q;
	assign cur_sum = 33'(cur_c) + 33'(cur_w);
	assign max_size = (width_q > height_q) ? width_q : height_q;
	assign limit = {max_size, 10'b0};

	assign prod_mag = prod_q[65] ? 66'(-prod_q) : 66'(prod_q);
	assign cut_rnd = prod_mag + CUT_HALF;
	assign cut_r = {1'b0, cut_rnd[62:30]};
	assign cut_sum = 34'(pc) + (prod_q[65] ? -$signed(cut_r) : $signed(cut_r));

	assign proj_num = {prod_mag[46:0], 7'b0} + {23'b0, cur_w[31:1]};
	assign proj_q = div_quot[53:0];
	assign proj_clamp = (proj_q > {31'b0, limit}) ? limit : proj_q[22:0];

	assign cur_s = s_q[k_q];
	assign snap_mag = cur_s[OUT_W-1] ? OUT_W'(-cur_s) : OUT_W'(cur_s);
	assign snap_num = {1'b0, snap_mag} + {10'b0, snap_q[SNAP_W-1:1]};
	assign snap_over_p = |prod_q[65:23];
	assign snap_over_n = (|prod_q[65:24]) || (prod_q[23] && (|prod_q[22:0]));
	always_comb begin
		if (neg_q)
			snap_res = snap_over_n ? {1'b1, {(OUT_W-1){1'b0}}} : -prod_q[OUT_W-1:0];
		else
			snap_res = snap_over_p ? {1'b0, {(OUT_W-1){1'b1}}} : prod_q[OUT_W-1:0];
	end

	assign zero_len = (s_q[0] == s_q[2]) && (s_q[1] == s_q[3]);
	assign out_free = !m_valid_q || m_tready;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_CUT_MUL: begin
				mul_a = 34'(qc) - 34'(pc);
				mul_b = 32'(t_q);
			end
			ST_PROJ_MUL: begin
				mul_a = 34'(cur_sum);
				mul_b = 32'(cur_size);
			end
			ST_SNAP_MUL: begin
				mul_a = 34'(div_quot[24:0]);
				mul_b = 32'(snap_q);
			end
			default: ;
		endcase
	end

	always_comb begin
		div_req = '0;
		unique case (state_q)
			ST_CLIP_DIV: begin
				div_req.start = 1'b1;
				div_req.iters = CLIP_ITERS;
				div_req.num = {near_diff[31:0], 32'b0};
				div_req.den = clip_den;
			end
			ST_PROJ_DIV: begin
				div_req.start = 1'b1;
				div_req.iters = PROJ_ITERS;
				div_req.num = {proj_num, 10'b0};
				div_req.den = 33'(cur_w);
			end
			ST_SNAP_DIV: begin
				div_req.start = 1'b1;
				div_req.iters = SNAP_ITERS;
				div_req.num = {snap_num, 39'b0};
				div_req.den = 33'(snap_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (cnt_full || (behind_a && behind_b))
					state_d = ST_IDLE;
				else if (behind_a || behind_b)
					state_d = ST_CLIP_DIV;
				else
					state_d = ST_PROJ_MUL;
			end
			ST_CLIP_DIV: state_d = ST_CLIP_WAIT;
			ST_CLIP_WAIT: if (div_done) state_d = ST_CUT_MUL;
			ST_CUT_MUL: state_d = ST_CUT_ADD;
			ST_CUT_ADD: state_d = half_q ? ST_PROJ_MUL : ST_CUT_MUL;
			ST_PROJ_MUL: state_d = ST_PROJ_DIV;
			ST_PROJ_DIV: state_d = ST_PROJ_WAIT;
			ST_PROJ_WAIT: begin
				if (div_done)
					state_d = (snap_q != '0) ? ST_SNAP_DIV : ST_NEXT;
			end
			ST_SNAP_DIV: state_d = ST_SNAP_WAIT;
			ST_SNAP_WAIT: if (div_done) state_d = ST_SNAP_MUL;
			ST_SNAP_MUL: state_d = ST_SNAP_SAT;
			ST_SNAP_SAT: state_d = ST_NEXT;
			ST_NEXT: state_d = (k_q == 2'd3) ? ST_EMIT : ST_PROJ_MUL;
			ST_EMIT: begin
				if (zero_len || out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			snap_q <= '0;
			maxseg_q <= MAXSEG_RST;
			cnt_q <= '0;
			m_valid_q <= 1'b0;
			k_q <= '0;
			half_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SCREEN_WIDTH: width_q <= cfg_data[SIZE_W-1:0];
					REG_SCREEN_HEIGHT: height_q <= cfg_data[SIZE_W-1:0];
					REG_SNAP_STEP: snap_q <= cfg_data;
					REG_MAX_SEGMENTS: maxseg_q <= cfg_data[SIZE_W-1:0];
					default: ;
				endcase
			end
			if (state_q == ST_EMIT && !zero_len && out_free)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
			unique case (state_q)
				ST_CHECK: begin
					cnt_q <= cnt_eff;
					k_q <= '0;
					half_q <= 1'b0;
				end
				ST_CUT_ADD: half_q <= ~half_q;
				ST_NEXT: k_q <= k_q + 2'd1;
				ST_EMIT: begin
					if (!zero_len && out_free)
						cnt_q <= cnt_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					c_q[0] <= s_tdata[31:0];
					c_q[1] <= s_tdata[63:32];
					w_q[0] <= s_tdata[95:64];
					c_q[2] <= s_tdata[127:96];
					c_q[3] <= s_tdata[159:128];
					w_q[1] <= s_tdata[191:160];
					tag_q <= s_tdata[223:192];
					fs_q <= s_tuser;
				end
			end
			ST_CHECK: bsel_q <= !behind_a;
			ST_CLIP_WAIT: if (div_done) t_q <= div_quot[T_BITS:0];
			ST_CUT_ADD: begin
				c_q[{bsel_q, half_q}] <= cut_sum[IN_W-1:0];
				if (half_q)
					w_q[bsel_q] <= NEAR_W;
			end
			ST_PROJ_DIV: neg_q <= prod_q[65];
			ST_PROJ_WAIT: begin
				if (div_done)
					s_q[k_q] <= neg_q ? -$signed({1'b0, proj_clamp})
						: $signed({1'b0, proj_clamp});
			end
			ST_SNAP_DIV: neg_q <= cur_s[OUT_W-1];
			ST_SNAP_SAT: s_q[k_q] <= snap_res;
			ST_EMIT: begin
				if (!zero_len && out_free)
					m_data_q <= {tag_q, s_q[3], s_q[2], s_q[1], s_q[0]};
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;

endmodule

`default_nettype wire
